// File: rtl/core/bdq_pkg.sv
// Shared sizes, operation and status codes, and memory request type for the deque.
package bdq_pkg;

    localparam int DEPTH = 32;
    localparam int IDX_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    localparam logic [2:0] FN_DUMP       = 3'd0;
    localparam logic [2:0] FN_PUSH_FRONT = 3'd1;
    localparam logic [2:0] FN_PUSH_BACK  = 3'd2;
    localparam logic [2:0] FN_POP_FRONT  = 3'd3;
    localparam logic [2:0] FN_POP_BACK   = 3'd4;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_EMPTY = 2'd1;
    localparam logic [1:0] ST_FULL  = 2'd2;

    typedef struct packed {
        logic              we;
        logic              re;
        logic [IDX_W-1:0]  addr;
        logic [31:0]       wdata;
    } mem_req_t;

endpackage

// File: rtl/core/bdq_addr.sv
// Shared ring index unit: base plus offset, wrapped modulo the store depth.
module bdq_addr
    import bdq_pkg::*;
(
    input  logic [IDX_W-1:0] base,
    input  logic [IDX_W-1:0] offset,
    output logic [IDX_W-1:0] slot
);

    logic [IDX_W:0] sum;
    logic [IDX_W:0] wrapped;

    // Add, then fold back once; both operands stay below the depth
    always_comb
    begin
        sum     = {1'b0, base} + {1'b0, offset};
        wrapped = sum - (IDX_W + 1)'(DEPTH);
        if (sum >= (IDX_W + 1)'(DEPTH))
        begin
            slot = wrapped[IDX_W-1:0];
        end
        else
        begin
            slot = sum[IDX_W-1:0];
        end
    end

endmodule

// File: rtl/core/bdq_ram.sv
// Ring element store: one write or one registered read per cycle.
module bdq_ram
    import bdq_pkg::*;
(
    input  logic        clk,
    input  mem_req_t    req,
    output logic [31:0] rdata
);

    logic [31:0] mem [DEPTH];
    logic [31:0] rdata_reg;

    // Write on request
    always_ff @(posedge clk)
    begin
        if (req.we)
        begin
            mem[req.addr] <= req.wdata;
        end
    end

    // Register read data
    always_ff @(posedge clk)
    begin
        if (req.re)
        begin
            rdata_reg <= mem[req.addr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// File: rtl/core/bdq_ctrl.sv
// Operation sequencer: holds front index and count, drives the index unit and the store.
module bdq_ctrl
    import bdq_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         start,
    input  logic [2:0]   func,
    input  logic [31:0]  value,
    output logic         busy,
    output logic         res_strobe,
    output logic [31:0]  value_res,
    output logic [1:0]   status,
    output logic         last,
    output mem_req_t     mem_req,
    input  logic [31:0]  mem_rdata
);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_CALC  = 3'd1;
    localparam logic [2:0] S_WRITE = 3'd2;
    localparam logic [2:0] S_READ  = 3'd3;
    localparam logic [2:0] S_DATA  = 3'd4;

    logic [2:0]       state_reg, state_next;
    logic [2:0]       func_reg, func_next;
    logic [31:0]      val_reg, val_next;
    logic [IDX_W-1:0] front_reg, front_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic [CNT_W-1:0] iter_reg, iter_next;
    logic [IDX_W-1:0] addr_reg, addr_next;
    logic             strobe_reg, strobe_next;
    logic [31:0]      vres_reg, vres_next;
    logic [1:0]       status_reg, status_next;
    logic             last_reg, last_next;

    logic [IDX_W-1:0] unit_offset;
    logic [IDX_W-1:0] unit_slot;
    logic [CNT_W-1:0] count_dec;
    logic [CNT_W-1:0] iter_inc;
    logic             is_empty;
    logic             is_full;

    assign count_dec = count_reg - CNT_W'(1);
    assign iter_inc  = iter_reg + CNT_W'(1);
    assign is_empty  = (count_reg == '0);
    assign is_full   = (count_reg >= CNT_W'(DEPTH));

    // Pick the offset for the shared index unit
    always_comb
    begin
        unit_offset = '0;
        if (state_reg == S_DATA)
        begin
            unit_offset = IDX_W'(1);
        end
        else
        begin
            unique case (func_reg)
                FN_PUSH_FRONT: unit_offset = IDX_W'(DEPTH - 1);
                FN_PUSH_BACK:  unit_offset = count_reg[IDX_W-1:0];
                FN_POP_BACK:   unit_offset = count_dec[IDX_W-1:0];
                FN_DUMP:       unit_offset = iter_reg[IDX_W-1:0];
                default:       unit_offset = '0;
            endcase
        end
    end

    bdq_addr u_addr (
        .base   (front_reg),
        .offset (unit_offset),
        .slot   (unit_slot)
    );

    // Sequence one operation
    always_comb
    begin
        state_next  = state_reg;
        func_next   = func_reg;
        val_next    = val_reg;
        front_next  = front_reg;
        count_next  = count_reg;
        iter_next   = iter_reg;
        addr_next   = addr_reg;
        strobe_next = 1'b0;
        vres_next   = vres_reg;
        status_next = status_reg;
        last_next   = last_reg;
        mem_req     = '{we: 1'b0, re: 1'b0, addr: addr_reg, wdata: val_reg};

        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    func_next  = func;
                    val_next   = value;
                    iter_next  = '0;
                    state_next = S_CALC;
                end
            end
            S_CALC:
            begin
                addr_next = unit_slot;
                priority if (func_reg == FN_PUSH_FRONT || func_reg == FN_PUSH_BACK)
                begin
                    if (is_full)
                    begin
                        strobe_next = 1'b1;
                        vres_next   = '0;
                        status_next = ST_FULL;
                        last_next   = 1'b1;
                        state_next  = S_IDLE;
                    end
                    else
                    begin
                        state_next = S_WRITE;
                    end
                end
                else if (func_reg == FN_POP_FRONT || func_reg == FN_POP_BACK
                         || func_reg == FN_DUMP)
                begin
                    if (is_empty)
                    begin
                        strobe_next = 1'b1;
                        vres_next   = '0;
                        status_next = ST_EMPTY;
                        last_next   = 1'b1;
                        state_next  = S_IDLE;
                    end
                    else
                    begin
                        state_next = S_READ;
                    end
                end
                else
                begin
                    // Drop unused codes silently
                    state_next = S_IDLE;
                end
            end
            S_WRITE:
            begin
                mem_req.we = 1'b1;
                if (func_reg == FN_PUSH_FRONT)
                begin
                    front_next = addr_reg;
                end
                count_next  = count_reg + CNT_W'(1);
                strobe_next = 1'b1;
                vres_next   = '0;
                status_next = ST_OK;
                last_next   = 1'b1;
                state_next  = S_IDLE;
            end
            S_READ:
            begin
                mem_req.re = 1'b1;
                state_next = S_DATA;
            end
            S_DATA:
            begin
                strobe_next = 1'b1;
                vres_next   = mem_rdata;
                status_next = ST_OK;
                if (func_reg == FN_DUMP)
                begin
                    // Advance to the next element or finish the stream
                    last_next = (iter_inc == count_reg);
                    iter_next = iter_inc;
                    if (iter_inc == count_reg)
                    begin
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        state_next = S_CALC;
                    end
                end
                else
                begin
                    last_next  = 1'b1;
                    count_next = count_dec;
                    if (func_reg == FN_POP_FRONT)
                    begin
                        front_next = unit_slot;
                    end
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            front_reg  <= '0;
            count_reg  <= '0;
            strobe_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            front_reg  <= front_next;
            count_reg  <= count_next;
            strobe_reg <= strobe_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        func_reg   <= func_next;
        val_reg    <= val_next;
        iter_reg   <= iter_next;
        addr_reg   <= addr_next;
        vres_reg   <= vres_next;
        status_reg <= status_next;
        last_reg   <= last_next;
    end

    assign busy       = (state_reg != S_IDLE);
    assign res_strobe = strobe_reg;
    assign value_res  = vres_reg;
    assign status     = status_reg;
    assign last       = last_reg;

endmodule

// File: rtl/core/bounded_deque_with_dump_top.sv
// Top level of the bounded double-ended queue with dump.
//
//  channel   | handshake            | beat contents
//  ----------+----------------------+------------------------------
//  command   | start, busy          | func, value
//  result    | res_strobe (1 cycle) | value_res, status, last
//
// A push runs the calculate and write states, a pop calculate, read and data,
// a dump calculate, read and data per element; a push into a full queue or a
// pop or dump of an empty one ends after calculate. Each element costs one pass
// through the shared index adder and one registered read of the single-port store.
// Reset clears front index, count and sequencer; the store is not cleared.
// The receiver cannot stall: each result beat is valid for one cycle only.
module bounded_deque_with_dump_top
    import bdq_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    input  logic [2:0]         func,
    input  logic signed [31:0] value,
    output logic               busy,
    output logic               res_strobe,
    output logic signed [31:0] value_res,
    output logic [1:0]         status,
    output logic               last
);

    mem_req_t    mem_req;
    logic [31:0] mem_rdata;
    logic [31:0] vres;

    bdq_ctrl u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (start),
        .func       (func),
        .value      (value),
        .busy       (busy),
        .res_strobe (res_strobe),
        .value_res  (vres),
        .status     (status),
        .last       (last),
        .mem_req    (mem_req),
        .mem_rdata  (mem_rdata)
    );

    bdq_ram u_ram (
        .clk   (clk),
        .req   (mem_req),
        .rdata (mem_rdata)
    );

    assign value_res = vres;

endmodule
